[hdl/rsvg_pkg.sv]
package rsvg_pkg;

    localparam int SLOTS       = 256;
    localparam int ANGLE_STEPS = 360;
    localparam int ENTRIES     = 3 * SLOTS;
    localparam int IDX_W       = $clog2(ENTRIES);

    localparam logic [1:0] MODE_CIRCLE = 2'd0;
    localparam logic [1:0] MODE_RECT   = 2'd1;
    localparam logic [1:0] MODE_TRI    = 2'd2;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] HALF_Q30 = 64'd536870912;

    // 6x corner coordinates and pipeline widths
    localparam int CW = 20;
    localparam int PW = CW + 16;
    localparam int UW = 22;
    localparam logic [23:0] RECIP3 = 24'd11184811;

    typedef logic [14:0] qsin_tab_t [0:90];

    typedef struct packed {
        logic        seen;
        logic [15:0] x;
        logic [15:0] y;
        logic [8:0]  rot;
    } slot_entry_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [9:0]  bpos;
        logic        tu;
        logic        tv;
        logic [31:0] color;
        logic        last;
        logic [15:0] ox;
        logic [15:0] oy;
    } vert_tag_t;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        vert_tag_t            tag;
    } corner_t;

    function automatic qsin_tab_t build_qsin();
        qsin_tab_t   t;
        logic [63:0] x;
        logic [63:0] term;
        logic signed [63:0] sum;
        for (int k = 0; k <= 90; k++)
        begin
            x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 12; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 0;
            t[k] = 15'(($unsigned(sum) * 64'd16384 + HALF_Q30) >> 30);
        end
        return t;
    endfunction

    localparam qsin_tab_t QSIN = build_qsin();

    function automatic logic signed [15:0] sin_q14(input logic [8:0] ang);
        logic signed [15:0] r;
        if (ang <= 9'd90)
            r = $signed({1'b0, QSIN[ang[6:0]]});
        else if (ang <= 9'd180)
            r = $signed({1'b0, QSIN[7'(9'd180 - ang)]});
        else if (ang <= 9'd270)
            r = -$signed({1'b0, QSIN[7'(ang - 9'd180)]});
        else
            r = -$signed({1'b0, QSIN[7'(9'd360 - ang)]});
        return r;
    endfunction

    function automatic logic signed [15:0] cos_q14(input logic [8:0] ang);
        logic [9:0] a;
        a = {1'b0, ang} + 10'd90;
        if (a >= 10'd360)
            a = a - 10'd360;
        return sin_q14(a[8:0]);
    endfunction

endpackage

[hdl/rsvg_slot_mem.sv]
module rsvg_slot_mem (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [rsvg_pkg::IDX_W-1:0] rd_addr,
    output rsvg_pkg::slot_entry_t      rd_data,
    input  logic                       wr_en,
    input  logic [rsvg_pkg::IDX_W-1:0] wr_addr,
    input  rsvg_pkg::slot_entry_t      wr_data
);
    import rsvg_pkg::*;

    slot_entry_t mem [0:ENTRIES-1];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/rsvg_rotate.sv]
module rsvg_rotate (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rsvg_pkg::corner_t       corner,
    input  logic signed [15:0]      sin_val,
    input  logic signed [15:0]      cos_val,
    output logic                    adv,
    output logic                    out_valid,
    input  logic                    out_stall,
    output rsvg_pkg::vert_tag_t     out_tag,
    output logic signed [17:0]      out_x,
    output logic signed [17:0]      out_y
);
    import rsvg_pkg::*;

    logic                 v1_reg, v2_reg, v3_reg;
    vert_tag_t            tag1_reg, tag2_reg, tag3_reg;
    logic signed [PW-1:0] xc_reg, ys_reg, xs_reg, yc_reg;
    logic [UW-1:0]        ux_reg, uy_reg;
    logic signed [17:0]   x3_reg, y3_reg;

    logic signed [PW:0]   rx, ry;
    logic signed [PW-15:0] tx, ty;
    logic [UW-1:0]        ux_next, uy_next;
    logic [UW+23:0]       mx, my;
    logic signed [22:0]   vx, vy;

    function automatic logic signed [17:0] sat18(input logic signed [22:0] v);
        if (v > 23'sd131071)
            return 18'sd131071;
        else if (v < -23'sd131072)
            return -18'sd131072;
        else
            return v[17:0];
    endfunction

    assign adv = !v3_reg || !out_stall;

    // floor((r + 49152) / 98304): shift out 32768, then divide by three
    always_comb
    begin
        rx = (PW+1)'(xc_reg) - (PW+1)'(ys_reg) + (PW+1)'(49152);
        ry = (PW+1)'(xs_reg) + (PW+1)'(yc_reg) + (PW+1)'(49152);
        tx = rx[PW:15];
        ty = ry[PW:15];
        ux_next = UW'(tx) + UW'(3 * (1 << 20));
        uy_next = UW'(ty) + UW'(3 * (1 << 20));
        mx = (UW+24)'(ux_reg) * (UW+24)'(RECIP3);
        my = (UW+24)'(uy_reg) * (UW+24)'(RECIP3);
        vx = $signed({2'b00, mx[UW+23:25]}) - 23'sd1048576
             + 23'($signed(tag2_reg.ox));
        vy = $signed({2'b00, my[UW+23:25]}) - 23'sd1048576
             + 23'($signed(tag2_reg.oy));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= corner.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xc_reg   <= PW'(corner.cx * cos_val);
            ys_reg   <= PW'(corner.cy * sin_val);
            xs_reg   <= PW'(corner.cx * sin_val);
            yc_reg   <= PW'(corner.cy * cos_val);
            tag1_reg <= corner.tag;
            ux_reg   <= ux_next;
            uy_reg   <= uy_next;
            tag2_reg <= tag1_reg;
            x3_reg   <= sat18(vx);
            y3_reg   <= sat18(vy);
            tag3_reg <= tag2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_tag   = tag3_reg;
    assign out_x     = x3_reg;
    assign out_y     = y3_reg;

endmodule

[hdl/rotated_shape_vertex_generator.sv]
// Shape-to-vertex generator. Each accepted word describes one circle, rectangle
// or triangle and yields four vertices (three for a triangle) on the output
// channel, or none when the slot is unchanged and skipping is on, or when mode
// or slot is out of range. After reset the block clears its 768-entry slot
// memory, one entry per cycle, and holds in_stall high while it does so.
// An item then passes through rotation reduction and slot lookup (S_LOOK,
// S_DECIDE), and S_EMIT issues its corners in turn, holding while the output
// stalls, into a three-stage multiply pipeline; the slot memory read and
// write-back set the per-item sequence.
module rotated_shape_vertex_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [7:0]         slot,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [14:0]        size_a,
    input  logic [14:0]        size_b,
    input  logic [15:0]        rotation_deg,
    input  logic [31:0]        color,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [9:0]         buffer_pos,
    output logic signed [17:0] vert_x,
    output logic signed [17:0] vert_y,
    output logic               tex_u,
    output logic               tex_v,
    output logic [31:0]        vert_color,
    output logic               last
);
    import rsvg_pkg::*;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOOK, S_DECIDE, S_EMIT} state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   clr_reg;
    logic               skip_reg;
    logic [1:0]         mode_reg;
    logic [7:0]         slot_reg;
    logic               slot_ok_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [15:0]        px_reg, py_reg;
    logic [14:0]        a_reg, b_reg;
    logic [15:0]        rraw_reg;
    logic [7:0]         q_reg;
    logic [8:0]         rot_reg;
    logic [31:0]        color_reg;
    logic signed [15:0] s_reg, c_reg;
    logic [1:0]         j_reg;

    logic               accept;
    logic [IDX_W-1:0]   idx_next;
    logic [31:0]        qprod;
    logic [16:0]        rem;
    slot_entry_t        rd_data, wr_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               adv;
    logic               launch;
    logic               lastc;
    corner_t            corner;
    vert_tag_t          out_tag;
    logic signed [CW-1:0] a6, b6, a3, a2;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign idx_next = IDX_W'(IDX_W'(mode) * IDX_W'(SLOTS)) + IDX_W'(slot);
    assign qprod    = 32'(rotation_deg) * 32'd46603;
    assign rem      = {1'b0, rraw_reg} - 17'(q_reg * 17'd360);

    rsvg_slot_mem u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (idx_next),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '{seen: 1'b1, x: px_reg, y: py_reg, rot: rot_reg};
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if (state_reg == S_DECIDE && mode_reg != 2'd3 && slot_ok_reg &&
                 !(skip_reg && rd_data.seen && rd_data.x == px_reg &&
                   rd_data.y == py_reg && rd_data.rot == rot_reg))
            wr_en = 1'b1;
    end

    // corners at six times their value
    always_comb
    begin
        a6 = CW'(a_reg) * CW'(6);
        b6 = CW'(b_reg) * CW'(6);
        a3 = CW'(a_reg) * CW'(3);
        a2 = CW'(a_reg) * CW'(2);
        launch = (state_reg == S_EMIT) && adv;
        lastc  = (mode_reg == MODE_TRI) ? (j_reg == 2'd2) : (j_reg == 2'd3);
        corner.valid     = launch;
        corner.tag.mode  = mode_reg;
        corner.tag.bpos  = (mode_reg == MODE_TRI)
                           ? 10'(10'({slot_reg, 1'b0}) + 10'(slot_reg) + 10'(j_reg))
                           : 10'({slot_reg, j_reg});
        corner.tag.tu    = (mode_reg == MODE_CIRCLE) && j_reg[0];
        corner.tag.tv    = (mode_reg == MODE_CIRCLE) && j_reg[1];
        corner.tag.color = (mode_reg == MODE_CIRCLE) ? 32'hFFFF_FFFF : color_reg;
        corner.tag.last  = lastc;
        corner.tag.ox    = px_reg;
        corner.tag.oy    = py_reg;
        if (mode_reg == MODE_TRI)
        begin
            case (j_reg)
                2'd0:
                begin
                    corner.cx = '0;
                    corner.cy = a2 - b6;
                end
                2'd1:
                begin
                    corner.cx = -a3;
                    corner.cy = a2;
                end
                default:
                begin
                    corner.cx = a3;
                    corner.cy = a2;
                end
            endcase
        end
        else
        begin
            corner.cx = j_reg[0] ? a6 : -a6;
            if (mode_reg == MODE_CIRCLE)
                corner.cy = j_reg[1] ? a6 : -a6;
            else
                corner.cy = j_reg[1] ? b6 : -b6;
        end
    end

    rsvg_rotate u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .corner    (corner),
        .sin_val   (s_reg),
        .cos_val   (c_reg),
        .adv       (adv),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_tag   (out_tag),
        .out_x     (vert_x),
        .out_y     (vert_y)
    );

    assign kind       = out_tag.mode;
    assign buffer_pos = out_tag.bpos;
    assign tex_u      = out_tag.tu;
    assign tex_v      = out_tag.tv;
    assign vert_color = out_tag.color;
    assign last       = out_tag.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            skip_reg  <= 1'b1;
            j_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                skip_reg <= cfg_wr_data;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IDX_W'(ENTRIES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (accept)
                        state_reg <= S_LOOK;
                S_LOOK:
                    state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    j_reg <= '0;
                    state_reg <= wr_en ? S_EMIT : S_IDLE;
                end
                S_EMIT:
                    if (launch)
                    begin
                        j_reg <= j_reg + 1'b1;
                        if (lastc)
                            state_reg <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode;
            slot_reg    <= slot;
            slot_ok_reg <= (32'(slot) < 32'(SLOTS));
            idx_reg     <= idx_next;
            px_reg      <= pos_x;
            py_reg      <= pos_y;
            a_reg       <= size_a;
            b_reg       <= size_b;
            rraw_reg    <= rotation_deg;
            q_reg       <= qprod[31:24];
            color_reg   <= color;
        end
        // reciprocal estimate can sit one below the true quotient
        if (state_reg == S_LOOK)
            rot_reg <= (rem >= 17'd360) ? 9'(rem - 17'd360) : rem[8:0];
        if (state_reg == S_DECIDE)
        begin
            s_reg <= sin_q14(rot_reg);
            c_reg <= cos_q14(rot_reg);
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import rsvg_pkg::*;

    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  slot;
        logic [15:0] px;
        logic [15:0] py;
        logic [14:0] sa;
        logic [14:0] sb;
        logic [15:0] rot;
        logic [31:0] color;
    } shape_t;

    typedef struct {
        logic [1:0]  kind;
        logic [9:0]  bpos;
        logic [17:0] vx;
        logic [17:0] vy;
        logic        tu;
        logic        tv;
        logic [31:0] color;
        logic        last;
    } vertex_t;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE       = 30;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    logic in_valid;
    logic in_stall;
    logic [1:0] mode;
    logic [7:0] slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0] size_a;
    logic [14:0] size_b;
    logic [15:0] rotation_deg;
    logic [31:0] color;
    logic out_valid;
    logic out_stall;
    logic [1:0] kind;
    logic [9:0] buffer_pos;
    logic signed [17:0] vert_x;
    logic signed [17:0] vert_y;
    logic tex_u;
    logic tex_v;
    logic [31:0] vert_color;
    logic last;

    rotated_shape_vertex_generator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .slot(slot), .pos_x(pos_x), .pos_y(pos_y),
        .size_a(size_a), .size_b(size_b), .rotation_deg(rotation_deg), .color(color),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .buffer_pos(buffer_pos), .vert_x(vert_x), .vert_y(vert_y),
        .tex_u(tex_u), .tex_v(tex_v), .vert_color(vert_color), .last(last)
    );

    // predictor state
    longint sin_tab [0:359];
    longint cos_tab [0:359];
    logic        skip_on;
    logic [15:0] held_x   [0:ENTRIES-1];
    logic [15:0] held_y   [0:ENTRIES-1];
    logic [8:0]  held_rot [0:ENTRIES-1];
    logic        held_ok  [0:ENTRIES-1];

    vertex_t pending_verts [$];
    int      mismatches;
    int      cycles;
    int      send_gap_max;
    int      recv_gap_max;
    int      hold_off;
    shape_t  prev;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = 1'b1;
            #1 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint quarter_sine(int k);
        longint unsigned x;
        longint unsigned term;
        longint sum;
        x    = (longint'(k) * 64'd3373259426 + 64'd90) / 64'd180;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 12; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        return longint'(($unsigned(sum) * 64'd16384 + 64'd536870912) >> 30);
    endfunction

    function automatic longint sine_deg(int i);
        i = i % 360;
        if (i <= 90)
            return quarter_sine(i);
        if (i <= 180)
            return quarter_sine(180 - i);
        if (i <= 270)
            return -quarter_sine(i - 180);
        return -quarter_sine(360 - i);
    endfunction

    function automatic logic [17:0] place(longint r, logic [15:0] org);
        longint v;
        longint q;
        v = r + 49152;
        q = v / 98304;
        if ((v % 98304) != 0 && v < 0)
            q = q - 1;
        q = q + longint'($signed(org));
        if (q > 131071)
            q = 131071;
        if (q < -131072)
            q = -131072;
        return q[17:0];
    endfunction

    // work out the vertices of one accepted shape and update the slot store
    task automatic predict_vertices(input shape_t s);
        int      idx;
        int      count;
        int      ang;
        longint  a, b, sn, cs, off;
        longint  cx [4];
        longint  cy [4];
        vertex_t v;
        if (s.mode > MODE_TRI)
            return;
        idx = int'(s.mode) * SLOTS + int'(s.slot);
        ang = int'(s.rot) % 360;
        if (skip_on && held_ok[idx] && held_x[idx] == s.px && held_y[idx] == s.py
            && held_rot[idx] == 9'(ang))
            return;
        a = longint'(s.sa);
        b = longint'(s.sb);
        if (s.mode == MODE_TRI)
        begin
            off   = 2 * a;
            count = 3;
            cx[0] = 0;      cy[0] = -6 * b + off;
            cx[1] = -3 * a; cy[1] = off;
            cx[2] = 3 * a;  cy[2] = off;
        end
        else
        begin
            count = 4;
            off   = (s.mode == MODE_CIRCLE) ? 6 * a : 6 * b;
            cx[0] = -6 * a; cy[0] = -off;
            cx[1] = 6 * a;  cy[1] = -off;
            cx[2] = -6 * a; cy[2] = off;
            cx[3] = 6 * a;  cy[3] = off;
        end
        sn = sin_tab[ang];
        cs = cos_tab[ang];
        for (int j = 0; j < count; j++)
        begin
            v.kind  = s.mode;
            v.bpos  = 10'(int'(s.slot) * count + j);
            v.vx    = place(cx[j] * cs - cy[j] * sn, s.px);
            v.vy    = place(cx[j] * sn + cy[j] * cs, s.py);
            v.tu    = (s.mode == MODE_CIRCLE) ? 1'(j % 2) : 1'b0;
            v.tv    = (s.mode == MODE_CIRCLE) ? 1'(j / 2) : 1'b0;
            v.color = (s.mode == MODE_CIRCLE) ? 32'hFFFF_FFFF : s.color;
            v.last  = (j == count - 1);
            pending_verts.push_back(v);
        end
        held_x[idx]   = s.px;
        held_y[idx]   = s.py;
        held_rot[idx] = 9'(ang);
        held_ok[idx]  = 1'b1;
    endtask

    task automatic send_shape(input shape_t s);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode = s.mode; slot = s.slot; pos_x = s.px; pos_y = s.py;
        size_a = s.sa; size_b = s.sb; rotation_deg = s.rot; color = s.color;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_vertices(s);
        prev = s;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain_all();
        while (pending_verts.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_skip(input logic val);
        drain_all();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        skip_on   = val;
    endtask

    function automatic shape_t make_shape(logic [1:0] m, logic [7:0] sl, logic [15:0] x,
                                          logic [15:0] y, logic [14:0] a, logic [14:0] b,
                                          logic [15:0] r, logic [31:0] c);
        shape_t s;
        s.mode = m; s.slot = sl; s.px = x; s.py = y;
        s.sa = a; s.sb = b; s.rot = r; s.color = c;
        return s;
    endfunction

    function automatic shape_t random_shape();
        shape_t s;
        int pick;
        s.mode  = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        s.slot  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        s.px    = 16'($urandom);
        s.py    = 16'($urandom);
        pick    = $urandom_range(0, 3);
        s.sa    = (pick == 0) ? 15'($urandom) : 15'($urandom_range(0, 1023));
        s.sb    = (pick == 1) ? 15'($urandom) : 15'($urandom_range(0, 1023));
        s.rot   = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 719));
        s.color = $urandom;
        // revisit the previous slot, often unchanged, to exercise skipping
        if ($urandom_range(0, 4) == 0)
        begin
            s.mode = prev.mode;
            s.slot = prev.slot;
            if ($urandom_range(0, 2) != 0)
            begin
                s.px = prev.px;
                s.py = prev.py;
                s.rot = ($urandom_range(0, 1) == 0) ? prev.rot : 16'(prev.rot % 360 + 360);
            end
        end
        return s;
    endfunction

    // receiver: random stall per word, with an occasional long hold
    initial
    begin
        int n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                n = hold_off;
                hold_off = 0;
            end
            else
                n = $urandom_range(0, recv_gap_max);
            out_stall = 1'b1;
            repeat (n) @(negedge clk);
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        vertex_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex kind %0d pos %0d", kind, buffer_pos);
            end
            else
            begin
                e = pending_verts.pop_front();
                if (e.kind !== kind || e.bpos !== buffer_pos || e.vx !== vert_x
                    || e.vy !== vert_y || e.tu !== tex_u || e.tv !== tex_v
                    || e.color !== vert_color || e.last !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch exp k%0d p%0d x%h y%h t%b%b c%h l%b",
                                 e.kind, e.bpos, e.vx, e.vy, e.tu, e.tv, e.color, e.last,
                                 " / got k%0d p%0d x%h y%h t%b%b c%h l%b",
                                 kind, buffer_pos, vert_x, vert_y, tex_u, tex_v,
                                 vert_color, last);
                end
            end
        end
    end

    task automatic test_extremes();
        send_shape(make_shape(MODE_RECT, 8'd0, 16'h0000, 16'h0000, 15'd0, 15'd0, 16'd0, 32'h0));
        send_shape(make_shape(MODE_RECT, 8'd255, 16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF,
                              16'd45, 32'hFFFF_FFFF));
        send_shape(make_shape(MODE_RECT, 8'd254, 16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF,
                              16'hFFFF, 32'hA5A5_5A5A));
        send_shape(make_shape(MODE_CIRCLE, 8'd255, 16'h8000, 16'h7FFF, 15'h7FFF, 15'd0,
                              16'd90, 32'h1234_5678));
        send_shape(make_shape(MODE_CIRCLE, 8'd1, 16'h0010, 16'hFFF0, 15'd16, 15'h7FFF,
                              16'd359, 32'h0));
        send_shape(make_shape(MODE_TRI, 8'd255, 16'h7FFF, 16'h8000, 15'h7FFF, 15'h7FFF,
                              16'd180, 32'h5A5A_A5A5));
        send_shape(make_shape(MODE_TRI, 8'd0, 16'h0100, 16'h0100, 15'd3, 15'd7, 16'd270,
                              32'hFF00_00FF));
        send_shape(make_shape(MODE_TRI, 8'd1, 16'h0000, 16'h0000, 15'd0, 15'd0, 16'd360,
                              32'h0));
        send_shape(make_shape(2'd3, 8'd5, 16'h1234, 16'h4321, 15'd100, 15'd200, 16'd10,
                              32'hDEAD_BEEF));
    endtask

    task automatic test_unchanged();
        shape_t s;
        s = make_shape(MODE_RECT, 8'd10, 16'h0230, 16'hFE00, 15'd80, 15'd40, 16'd30,
                       32'h1111_2222);
        send_shape(s);
        s.sa = 15'd999;
        s.color = 32'h3333_4444;
        send_shape(s);
        s.rot = 16'd390;
        send_shape(s);
        s.rot = 16'd31;
        send_shape(s);
        s.mode = MODE_CIRCLE;
        send_shape(s);
        s.sb = 15'd5;
        send_shape(s);
        s.px = 16'h0231;
        send_shape(s);
    endtask

    task automatic test_skip_off();
        shape_t s;
        write_skip(1'b0);
        s = make_shape(MODE_TRI, 8'd20, 16'h0400, 16'h0400, 15'd300, 15'd600, 16'd120,
                       32'h0F0F_F0F0);
        repeat (3) send_shape(s);
        for (int i = 0; i < 60; i++)
            send_shape(random_shape());
        write_skip(1'b1);
        repeat (2) send_shape(s);
    endtask

    task automatic test_long_hold();
        drain_all();
        hold_off = 400;
        for (int i = 0; i < 40; i++)
            send_shape(random_shape());
        drain_all();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0)
            begin
                send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
                recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
            end
            send_shape(random_shape());
        end
    endtask

    initial
    begin
        for (int i = 0; i < 360; i++)
        begin
            sin_tab[i] = sine_deg(i);
            cos_tab[i] = sine_deg(i + 90);
        end
        for (int i = 0; i < ENTRIES; i++)
            held_ok[i] = 1'b0;
        skip_on = 1'b1;
        mismatches = 0;
        cycles = 0;
        hold_off = 0;
        send_gap_max = 19;
        recv_gap_max = 19;
        prev = make_shape(MODE_RECT, 8'd0, 16'h0, 16'h0, 15'd0, 15'd0, 16'd0, 32'h0);
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        in_valid = 1'b0;
        mode = 2'd0; slot = 8'd0; pos_x = 16'sd0; pos_y = 16'sd0;
        size_a = 15'd0; size_b = 15'd0; rotation_deg = 16'd0; color = 32'd0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        write_skip(1'b1);
        test_extremes();
        test_unchanged();
        test_skip_off();
        test_long_hold();
        test_random(170);
        write_skip(1'b0);
        test_random(90);
        write_skip(1'b1);
        test_random(90);

        drain_all();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
